@@ hw/rtl/ecf_pkg.sv @@
package ecf_pkg;

    // Width that holds every fixed seconds constant of the converter.
    localparam int CONST_W = 34;

    localparam logic [CONST_W-1:0] SECS_PER_DAY  = CONST_W'(86400);
    localparam logic [CONST_W-1:0] SECS_PER_HOUR = CONST_W'(3600);
    localparam logic [CONST_W-1:0] SECS_PER_MIN  = CONST_W'(60);
    localparam logic [CONST_W-1:0] SECS_PER_400Y = CONST_W'(64'd146097 * 64'd86400);
    localparam logic [CONST_W-1:0] SECS_LEAP_YR  = CONST_W'(366 * 86400);
    localparam logic [CONST_W-1:0] SECS_COMMON_YR = CONST_W'(365 * 86400);

    localparam logic [CONST_W-1:0] BASE_2016 = CONST_W'(32'h5685_C180);
    localparam logic [CONST_W-1:0] BASE_2010 = CONST_W'(32'h4B3D_3B00);
    localparam logic [CONST_W-1:0] BASE_2000 = CONST_W'(32'h386D_4380);

    localparam logic [16:0] ZONE_RESET = 17'd28800;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_B2016  = 11'b000_0000_0010,
        ST_B2010  = 11'b000_0000_0100,
        ST_B2000  = 11'b000_0000_1000,
        ST_Y400   = 11'b000_0001_0000,
        ST_YEAR   = 11'b000_0010_0000,
        ST_MONTH  = 11'b000_0100_0000,
        ST_DAY    = 11'b000_1000_0000,
        ST_HOUR   = 11'b001_0000_0000,
        ST_MINUTE = 11'b010_0000_0000,
        ST_SPARE  = 11'b100_0000_0000
    } state_t;

    // Length in seconds of month index mon (0 is January).
    function automatic logic [CONST_W-1:0] month_secs(input logic leap, input logic [3:0] mon);
        logic [4:0] days;
        begin
            unique case (mon)
                4'd1:    days = leap ? 5'd29 : 5'd28;
                4'd3,
                4'd5,
                4'd8,
                4'd10:   days = 5'd30;
                default: days = 5'd31;
            endcase
            month_secs = CONST_W'(days) * SECS_PER_DAY;
        end
    endfunction

endpackage

@@ hw/rtl/ecf_sub.sv @@
module ecf_sub #(
    parameter int W = 34
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    // Borrow set means b is larger than a and the difference is not taken.
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

@@ hw/rtl/epoch_to_calendar_fields.sv @@
// The converter subtracts base-year offsets (2016, then 2010, then 2000 or 1970), then
// 400-year, single-year, month, day, hour and minute lengths in turn, one state per kind.
// One item is converted at a time; busy stays high until the last step and a new item can
// be started in the cycle that done is shown. The receiver cannot stall the result.
// Reset: rst_n is asynchronous, active low; the zone offset returns to 28800 (GMT+8).
module epoch_to_calendar_fields
    import ecf_pkg::*;
#(
    parameter int EPOCH_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [EPOCH_BITS-1:0] epoch_seconds,
    input  logic                  cfg_wr_en,
    input  logic [16:0]           cfg_wr_data,
    output logic                  done,
    output logic [11:0]           year,
    output logic [3:0]            month,
    output logic [4:0]            day,
    output logic [4:0]            hour,
    output logic [5:0]            minute,
    output logic [5:0]            second,
    output logic                  clamped
);

    // The local time can exceed the input range by the largest positive offset, so the
    // working remainder carries one bit more than the input.
    localparam int TW = EPOCH_BITS + 1;
    // The shared subtractor must fit both the remainder and the widest constant.
    localparam int SW = (TW > CONST_W) ? TW : CONST_W;
    // The year grows by at most 2^(TW-24) from a base below 2^11.
    localparam int YW = (TW - 23 > 12) ? (TW - 23) : 12;

    state_t        state_reg, state_next;
    logic [16:0]   zone_reg;
    logic [TW-1:0] t_reg, t_next;
    logic [YW-1:0] year_reg, year_next;
    // Year modulo 400 and modulo 100 are tracked as counters so that the leap rule
    // needs no division.
    logic [8:0]    c400_reg, c400_next;
    logic [6:0]    c100_reg, c100_next;
    logic [3:0]    mon_reg, mon_next;
    logic [4:0]    day_reg, day_next;
    logic [4:0]    hour_reg, hour_next;
    logic [5:0]    min_reg, min_next;
    logic          clamp_reg, clamp_next;
    logic          done_reg, done_next;

    logic [TW:0]          local_sum;
    logic                 leap;
    logic [CONST_W-1:0]   operand;
    logic [SW-1:0]        sub_diff;
    logic                 sub_borrow;
    logic [TW-1:0]        diff_t;

    // The user must write the offset register only while no item is in flight; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= ZONE_RESET;
        end
        else if (cfg_wr_en)
        begin
            zone_reg <= cfg_wr_data;
        end
    end

    // Epoch plus the sign-extended offset, one bit wider so that a negative sum shows.
    assign local_sum = (TW + 1)'(epoch_seconds) + {{(TW + 1 - 17){zone_reg[16]}}, zone_reg};

    assign leap = (year_reg[1:0] == 2'b00) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));

    // Each state offers one constant to the shared subtractor.
    always_comb
    begin
        unique case (state_reg)
            ST_B2016:  operand = BASE_2016;
            ST_B2010:  operand = BASE_2010;
            ST_B2000:  operand = BASE_2000;
            ST_Y400:   operand = SECS_PER_400Y;
            ST_YEAR:   operand = leap ? SECS_LEAP_YR : SECS_COMMON_YR;
            ST_MONTH:  operand = month_secs(leap, mon_reg);
            ST_DAY:    operand = SECS_PER_DAY;
            ST_HOUR:   operand = SECS_PER_HOUR;
            ST_MINUTE: operand = SECS_PER_MIN;
            default:   operand = SECS_PER_MIN;
        endcase
    end

    ecf_sub #(
        .W (SW)
    ) u_sub (
        .a      (SW'(t_reg)),
        .b      (SW'(operand)),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // Without a borrow the difference is below t_reg and fits its width.
    assign diff_t = sub_diff[TW-1:0];

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        year_next  = year_reg;
        c400_next  = c400_reg;
        c100_next  = c100_reg;
        mon_next   = mon_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        clamp_next = clamp_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Local time before 1970 is pinned to the epoch itself.
                    if (local_sum[TW])
                    begin
                        t_next     = '0;
                        clamp_next = 1'b1;
                    end
                    else
                    begin
                        t_next     = local_sum[TW-1:0];
                        clamp_next = 1'b0;
                    end
                    mon_next   = 4'd0;
                    day_next   = 5'd1;
                    hour_next  = 5'd0;
                    min_next   = 6'd0;
                    state_next = ST_B2016;
                end
            end
            ST_B2016:
            begin
                if (!sub_borrow)
                begin
                    t_next     = diff_t;
                    year_next  = YW'(2016);
                    c400_next  = 9'd16;
                    c100_next  = 7'd16;
                    state_next = ST_Y400;
                end
                else
                begin
                    state_next = ST_B2010;
                end
            end
            ST_B2010:
            begin
                if (!sub_borrow)
                begin
                    t_next     = diff_t;
                    year_next  = YW'(2010);
                    c400_next  = 9'd10;
                    c100_next  = 7'd10;
                    state_next = ST_Y400;
                end
                else
                begin
                    state_next = ST_B2000;
                end
            end
            ST_B2000:
            begin
                if (!sub_borrow)
                begin
                    t_next    = diff_t;
                    year_next = YW'(2000);
                    c400_next = 9'd0;
                    c100_next = 7'd0;
                end
                else
                begin
                    year_next = YW'(1970);
                    c400_next = 9'd370;
                    c100_next = 7'd70;
                end
                state_next = ST_Y400;
            end
            ST_Y400:
            begin
                // A 400-year step leaves both leap counters where they are.
                if (!sub_borrow)
                begin
                    t_next    = diff_t;
                    year_next = year_reg + YW'(400);
                end
                else
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (!sub_borrow)
                begin
                    t_next    = diff_t;
                    year_next = year_reg + YW'(1);
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                end
                else
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                // December absorbs whatever is left.
                if (!sub_borrow && (mon_reg != 4'd11))
                begin
                    t_next   = diff_t;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (!sub_borrow)
                begin
                    t_next   = diff_t;
                    day_next = day_reg + 5'd1;
                end
                else
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (!sub_borrow)
                begin
                    t_next    = diff_t;
                    hour_next = hour_reg + 5'd1;
                end
                else
                begin
                    state_next = ST_MINUTE;
                end
            end
            ST_MINUTE:
            begin
                if (!sub_borrow)
                begin
                    t_next   = diff_t;
                    min_next = min_reg + 6'd1;
                end
                else
                begin
                    // The remainder is now the second of the minute.
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        year_reg  <= year_next;
        c400_reg  <= c400_next;
        c100_reg  <= c100_next;
        mon_reg   <= mon_next;
        day_reg   <= day_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        clamp_reg <= clamp_next;
    end

    // The working registers hold the finished fields during the cycle that done is high.
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign year    = year_reg[11:0];
    assign month   = mon_reg + 4'd1;
    assign day     = day_reg;
    assign hour    = hour_reg;
    assign minute  = min_reg;
    assign second  = t_reg[5:0];
    assign clamped = clamp_reg;

endmodule
